/* hw/rtl/owbm_pkg.sv */
// ----------------------------------------------------------------------------
// owbm_pkg: shared types and constants for the 1-Wire bus master
// Word formats, action codes, the decoded command word and config defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package owbm_pkg;

  localparam int unsigned CFG_NUM   = 8;
  localparam int unsigned CFG_W     = 10;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned TMR_W     = 10;
  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned BITS_W    = 4;

  // action codes
  localparam logic [2:0] ACT_TICK  = 3'd0;
  localparam logic [2:0] ACT_RESET = 3'd1;
  localparam logic [2:0] ACT_WBIT  = 3'd2;
  localparam logic [2:0] ACT_RBIT  = 3'd3;
  localparam logic [2:0] ACT_WBYTE = 3'd4;
  localparam logic [2:0] ACT_RBYTE = 3'd5;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRES_WAIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRES_REST  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WR1_LOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WR1_HIGH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WR0_LOW    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WR0_HIGH   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_LOW   = 3'd7;

  localparam logic [CFG_W-1:0] CFG_DEFAULT [CFG_NUM] = '{
    10'd480, 10'd70, 10'd410, 10'd10, 10'd55, 10'd65, 10'd5, 10'd5
  };

  // fixed read slot timing
  localparam logic [TMR_W-1:0] READ_SAMPLE_TIME = 10'd10;
  localparam logic [TMR_W-1:0] READ_REST_TIME   = 10'd55;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] tx_data;
    logic       line_level;
  } in_t;

  typedef struct packed {
    logic       pull_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] rx_data;
    logic       rejected;
  } out_t;

  typedef enum logic [1:0] {
    KIND_NOP,
    KIND_TICK,
    KIND_CMD
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [2:0] action;
    logic [7:0] tx_data;
    logic       line_level;
  } cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/one_wire_bus_master_top.sv */
// ----------------------------------------------------------------------------
// one_wire_bus_master_top: 1-Wire bus master
// Classifier, two-word queue and slot sequencer; one result word per input.
// ----------------------------------------------------------------------------
//  port group   dir  handshake              word
//  in_*         in   in_valid_i/in_stall_o  in_t  (action, tx_data, line_level)
//  out_*        out  out_valid_o/out_stall_i out_t (pull_low .. rejected)
//  cfg_*        in   cfg_we_i               cfg_idx_i, cfg_data_i
//
//  One word per cycle sustained when nothing stalls; each accepted input word
//  is written into the queue, then its result word into the output register.
//  in_stall_o rises only when the two-entry queue is full.
//  Reset restores the default slot timings and idles the bus (released).
// ----------------------------------------------------------------------------
`default_nettype none

module one_wire_bus_master_top import owbm_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  in_t                       in_word_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output out_t                      out_word_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  cmd_t front_cmd;
  cmd_t q_cmd;
  logic q_valid;
  logic q_pop;

  owbm_front u_front (
    .in_word_i (in_word_i),
    .cmd_o     (front_cmd)
  );

  owbm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_word_i (front_cmd),
    .full_o      (in_stall_o),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_word_o  (q_cmd)
  );

  owbm_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

/* hw/rtl/owbm_front.sv */
// ----------------------------------------------------------------------------
// owbm_front: input classifier
// Sorts each incoming word into tick, command or no-op and prepares its data.
// ----------------------------------------------------------------------------
`default_nettype none

module owbm_front import owbm_pkg::*; (
  input  in_t  in_word_i,
  output cmd_t cmd_o
);

  always_comb begin
    cmd_o.action     = in_word_i.action;
    cmd_o.line_level = in_word_i.line_level;
    cmd_o.tx_data    = in_word_i.tx_data;
    case (in_word_i.action)
      ACT_TICK:  cmd_o.kind = KIND_TICK;
      ACT_RESET,
      ACT_WBIT,
      ACT_RBIT,
      ACT_WBYTE,
      ACT_RBYTE: cmd_o.kind = KIND_CMD;
      default:   cmd_o.kind = KIND_NOP;
    endcase
    // write bit only sends bit 0
    if (in_word_i.action == ACT_WBIT) begin
      cmd_o.tx_data = {7'd0, in_word_i.tx_data[0]};
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/owbm_queue.sv */
// ----------------------------------------------------------------------------
// owbm_queue: two-entry word queue
// Decouples the classifier from the bus engine so each side stalls alone.
// ----------------------------------------------------------------------------
`default_nettype none

module owbm_queue import owbm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  cmd_t      push_word_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output cmd_t      pop_word_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o     = cnt_q == 2'd2;
  assign valid_o    = cnt_q != 2'd0;
  assign pop_word_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/owbm_engine.sv */
// ----------------------------------------------------------------------------
// owbm_engine: bus slot sequencer
// Holds the timing registers, runs reset/write/read slots one word per cycle
// while words arrive and the output is not stalled, and registers the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module owbm_engine import owbm_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 cmd_valid_i,
  input  cmd_t                      cmd_i,
  output logic                      cmd_pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output out_t                      out_word_o
);

  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_RST_LOW  = 4'd1;
  localparam logic [3:0] PH_RST_WAIT = 4'd2;
  localparam logic [3:0] PH_RST_REST = 4'd3;
  localparam logic [3:0] PH_WR_LOW   = 4'd4;
  localparam logic [3:0] PH_WR_HIGH  = 4'd5;
  localparam logic [3:0] PH_RD_LOW   = 4'd6;
  localparam logic [3:0] PH_RD_WAIT  = 4'd7;
  localparam logic [3:0] PH_RD_REST  = 4'd8;

  logic [CFG_W-1:0]  cfg_q [CFG_NUM];
  logic [3:0]        ph_q, ph_d;
  logic [2:0]        op_q, op_d;
  logic [TMR_W-1:0]  tmr_q, tmr_d;
  logic [BITS_W-1:0] bits_q, bits_d;
  logic [7:0]        shift_q, shift_d;
  logic              pres_q, pres_d;
  logic              drv_q, drv_d;
  logic [7:0]        rx_q, rx_d;
  logic              out_valid_q;
  out_t              out_word_q;
  logic              take;
  logic              done, rej, fin;
  logic [BITS_W-1:0] bits_n;

  // zero duration behaves as one microsecond
  function automatic logic [TMR_W-1:0] dur(input logic [CFG_W-1:0] v);
    dur = (v == '0) ? TMR_W'(1) : TMR_W'(v);
  endfunction

  assign take        = cmd_valid_i && (!out_valid_q || !out_stall_i);
  assign cmd_pop_o   = take;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  always_comb begin
    ph_d    = ph_q;
    op_d    = op_q;
    tmr_d   = tmr_q;
    bits_d  = bits_q;
    shift_d = shift_q;
    pres_d  = pres_q;
    drv_d   = drv_q;
    rx_d    = rx_q;
    done    = 1'b0;
    rej     = 1'b0;
    fin     = 1'b0;
    bits_n  = (bits_q != '0) ? bits_q - BITS_W'(1) : '0;

    case (cmd_i.kind)
      KIND_TICK: begin
        if (ph_q != PH_IDLE) begin
          if (tmr_q > TMR_W'(1)) begin
            tmr_d = tmr_q - TMR_W'(1);
          end else begin
            case (ph_q)
              PH_RST_LOW: begin
                ph_d  = PH_RST_WAIT;
                tmr_d = dur(cfg_q[CFG_PRES_WAIT]);
                drv_d = 1'b0;
              end
              PH_RST_WAIT: begin
                pres_d = ~cmd_i.line_level;  // presence is active low
                ph_d   = PH_RST_REST;
                tmr_d  = dur(cfg_q[CFG_PRES_REST]);
                drv_d  = 1'b0;
              end
              PH_RST_REST: fin = 1'b1;
              PH_WR_LOW: begin
                ph_d  = PH_WR_HIGH;
                tmr_d = shift_q[0] ? dur(cfg_q[CFG_WR1_HIGH]) : dur(cfg_q[CFG_WR0_HIGH]);
                drv_d = 1'b0;
              end
              PH_WR_HIGH: begin
                shift_d = {1'b0, shift_q[7:1]};
                bits_d  = bits_n;
                if (bits_n == '0) begin
                  fin = 1'b1;
                end else begin
                  ph_d  = PH_WR_LOW;
                  tmr_d = shift_q[1] ? dur(cfg_q[CFG_WR1_LOW]) : dur(cfg_q[CFG_WR0_LOW]);
                  drv_d = 1'b1;
                end
              end
              PH_RD_LOW: begin
                ph_d  = PH_RD_WAIT;
                tmr_d = READ_SAMPLE_TIME;
                drv_d = 1'b0;
              end
              PH_RD_WAIT: begin
                if (op_q == ACT_RBIT) begin
                  shift_d = {7'd0, cmd_i.line_level};
                end else begin
                  shift_d = {cmd_i.line_level, shift_q[7:1]};
                end
                ph_d  = PH_RD_REST;
                tmr_d = READ_REST_TIME;
                drv_d = 1'b0;
              end
              PH_RD_REST: begin
                bits_d = bits_n;
                if (bits_n == '0) begin
                  fin = 1'b1;
                end else begin
                  ph_d  = PH_RD_LOW;
                  tmr_d = dur(cfg_q[CFG_READ_LOW]);
                  drv_d = 1'b1;
                end
              end
              default: fin = 1'b1;
            endcase
            if (fin) begin
              ph_d   = PH_IDLE;
              tmr_d  = '0;
              drv_d  = 1'b0;
              bits_d = '0;
              done   = 1'b1;
              if (op_q == ACT_RBIT || op_q == ACT_RBYTE) begin
                rx_d = shift_d;
              end
            end
          end
        end
      end
      KIND_CMD: begin
        if (ph_q != PH_IDLE) begin
          rej = 1'b1;
        end else begin
          op_d  = cmd_i.action;
          drv_d = 1'b1;
          case (cmd_i.action)
            ACT_RESET: begin
              bits_d = '0;
              ph_d   = PH_RST_LOW;
              tmr_d  = dur(cfg_q[CFG_RESET_LOW]);
            end
            ACT_WBIT,
            ACT_WBYTE: begin
              bits_d  = (cmd_i.action == ACT_WBIT) ? BITS_W'(1) : BITS_W'(BYTE_BITS);
              shift_d = cmd_i.tx_data;
              ph_d    = PH_WR_LOW;
              tmr_d   = cmd_i.tx_data[0] ? dur(cfg_q[CFG_WR1_LOW]) : dur(cfg_q[CFG_WR0_LOW]);
            end
            ACT_RBIT: begin
              bits_d  = BITS_W'(1);
              shift_d = '0;
              ph_d    = PH_RD_LOW;
              tmr_d   = dur(cfg_q[CFG_READ_LOW]);
            end
            default: begin
              bits_d  = BITS_W'(BYTE_BITS);
              shift_d = '0;
              ph_d    = PH_RD_LOW;
              tmr_d   = dur(cfg_q[CFG_READ_LOW]);
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CFG_NUM; i++) begin
        cfg_q[i] <= CFG_DEFAULT[i];
      end
      ph_q        <= PH_IDLE;
      op_q        <= '0;
      tmr_q       <= '0;
      bits_q      <= '0;
      shift_q     <= '0;
      pres_q      <= 1'b0;
      drv_q       <= 1'b0;
      rx_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q[cfg_idx_i] <= cfg_data_i;
      end
      if (take) begin
        ph_q    <= ph_d;
        op_q    <= op_d;
        tmr_q   <= tmr_d;
        bits_q  <= bits_d;
        shift_q <= shift_d;
        pres_q  <= pres_d;
        drv_q   <= drv_d;
        rx_q    <= rx_d;
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_word_q.pull_low  <= drv_d;
      out_word_q.busy_res  <= ph_d != PH_IDLE;
      out_word_q.done_res  <= done;
      out_word_q.presence  <= pres_d;
      out_word_q.rx_data   <= rx_d;
      out_word_q.rejected  <= rej;
    end
  end

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for one_wire_bus_master_top
// Drives ticks and bus commands through the valid/stall input channel, keeps
// its own word-by-word copy of the slot sequencer, and checks every output word
// field by field. Covers idle items, default, shortest and long timings,
// commands while busy, a long output hold-off and random command sequences.
// ----------------------------------------------------------------------------
module tb import owbm_pkg::*;;

  localparam logic [2:0] ACT_SPARE0 = 3'd6;
  localparam logic [2:0] ACT_SPARE1 = 3'd7;
  localparam int unsigned DRAIN_LIMIT = 20000;
  localparam int unsigned TAIL_CYCLES = 8;

  typedef enum logic [3:0] {
    PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_RST_REST, PH_WR_LOW, PH_WR_HIGH,
    PH_RD_LOW, PH_RD_WAIT, PH_RD_REST
  } phase_e;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_t                  in_word = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_t                 out_word;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // bus sequencer copy
  phase_e           bus_phase = PH_IDLE;
  logic [2:0]       bus_op = '0;
  logic [TMR_W-1:0] slot_cnt = '0;
  logic [BITS_W-1:0] bits_rem = '0;
  logic [7:0]       shreg = '0;
  logic             pres_seen = 1'b0;
  logic             line_low = 1'b0;
  logic [7:0]       rx_last = '0;
  logic [CFG_W-1:0] slot_cfg [CFG_NUM];

  out_t expected_words [$];
  int   err_cnt = 0;
  int   work_items = 0;
  int   send_idle_pct = 6;
  int   recv_idle_pct = 58;
  int   hold_left = 0;

  one_wire_bus_master_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic flag_error(input string what);
    $display("ERROR @%0t: %s", $time, what);
    err_cnt++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) flag_error($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // ---------------------------------------------------------------- predictor
  function automatic void enter_phase(input phase_e ph, input logic [CFG_W-1:0] dur,
                                      input logic drv);
    bus_phase = ph;
    slot_cnt  = (dur == '0) ? TMR_W'(1) : TMR_W'(dur);
    line_low  = drv;
  endfunction

  function automatic void start_write_slot();
    enter_phase(PH_WR_LOW, shreg[0] ? slot_cfg[CFG_WR1_LOW] : slot_cfg[CFG_WR0_LOW], 1'b1);
  endfunction

  function automatic logic end_op();
    if (bus_op == ACT_RBIT || bus_op == ACT_RBYTE) rx_last = shreg;
    bus_phase = PH_IDLE;
    slot_cnt  = '0;
    line_low  = 1'b0;
    bits_rem  = '0;
    return 1'b1;
  endfunction

  function automatic out_t bus_next(input in_t w);
    out_t r;
    logic done;
    logic rej;
    done = 1'b0;
    rej  = 1'b0;
    if (w.action == ACT_TICK) begin
      if (bus_phase != PH_IDLE) begin
        if (slot_cnt > 1) begin
          slot_cnt--;
        end else begin
          case (bus_phase)
            PH_RST_LOW: enter_phase(PH_RST_WAIT, slot_cfg[CFG_PRES_WAIT], 1'b0);
            PH_RST_WAIT: begin
              pres_seen = ~w.line_level;  // presence is active low
              enter_phase(PH_RST_REST, slot_cfg[CFG_PRES_REST], 1'b0);
            end
            PH_RST_REST: done = end_op();
            PH_WR_LOW: enter_phase(PH_WR_HIGH,
                                   shreg[0] ? slot_cfg[CFG_WR1_HIGH] : slot_cfg[CFG_WR0_HIGH],
                                   1'b0);
            PH_WR_HIGH: begin
              shreg = shreg >> 1;
              if (bits_rem > 0) bits_rem--;
              if (bits_rem == 0) done = end_op();
              else start_write_slot();
            end
            PH_RD_LOW: enter_phase(PH_RD_WAIT, READ_SAMPLE_TIME, 1'b0);
            PH_RD_WAIT: begin
              if (bus_op == ACT_RBIT) shreg = {7'd0, w.line_level};
              else shreg = {w.line_level, shreg[7:1]};
              enter_phase(PH_RD_REST, READ_REST_TIME, 1'b0);
            end
            PH_RD_REST: begin
              if (bits_rem > 0) bits_rem--;
              if (bits_rem == 0) done = end_op();
              else enter_phase(PH_RD_LOW, slot_cfg[CFG_READ_LOW], 1'b1);
            end
            default: done = end_op();
          endcase
        end
      end
    end else if (w.action <= ACT_RBYTE) begin
      if (bus_phase != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        bus_op = w.action;
        case (w.action)
          ACT_RESET: begin
            bits_rem = '0;
            enter_phase(PH_RST_LOW, slot_cfg[CFG_RESET_LOW], 1'b1);
          end
          ACT_WBIT: begin
            bits_rem = BITS_W'(1);
            shreg    = {7'd0, w.tx_data[0]};
            start_write_slot();
          end
          ACT_WBYTE: begin
            bits_rem = BITS_W'(BYTE_BITS);
            shreg    = w.tx_data;
            start_write_slot();
          end
          ACT_RBIT: begin
            bits_rem = BITS_W'(1);
            shreg    = '0;
            enter_phase(PH_RD_LOW, slot_cfg[CFG_READ_LOW], 1'b1);
          end
          default: begin
            bits_rem = BITS_W'(BYTE_BITS);
            shreg    = '0;
            enter_phase(PH_RD_LOW, slot_cfg[CFG_READ_LOW], 1'b1);
          end
        endcase
      end
    end
    r.pull_low  = line_low;
    r.busy_res  = (bus_phase != PH_IDLE);
    r.done_res  = done;
    r.presence  = pres_seen;
    r.rx_data   = rx_last;
    r.rejected  = rej;
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic send_word(input in_t w);
    out_t r;
    logic was_busy;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    was_busy = (bus_phase != PH_IDLE);
    r = bus_next(w);
    expected_words.push_back(r);
    if (!(r.rejected || w.action > ACT_RBYTE || (w.action == ACT_TICK && !was_busy)))
      work_items++;
  endtask

  // ticks until the bus operation ends, mixing in random other words at a rate of noise_pct percent
  task automatic run_out(input logic [7:0] pat, input bit rand_lvl, input int noise_pct);
    in_t        w;
    logic [2:0] bit_idx;
    bit_idx = '0;
    while (bus_phase != PH_IDLE) begin
      w.tx_data = 8'($urandom);
      if ($urandom_range(99) < noise_pct) begin
        w.action     = 3'($urandom_range(ACT_RESET, ACT_SPARE1));
        w.line_level = 1'($urandom);
      end else begin
        w.action     = ACT_TICK;
        w.line_level = rand_lvl ? 1'($urandom) : pat[bit_idx];
        if ((bus_phase == PH_RD_WAIT || bus_phase == PH_RST_WAIT) && slot_cnt <= 1)
          bit_idx++;
      end
      send_word(w);
    end
  endtask

  task automatic run_op(input logic [2:0] act, input logic [7:0] tx, input logic [7:0] pat,
                        input bit rand_lvl, input int noise_pct);
    send_word(in_t'{act, tx, 1'($urandom)});
    run_out(pat, rand_lvl, noise_pct);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (expected_words.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (expected_words.size() != 0)
      flag_error($sformatf("%0d words never came out", expected_words.size()));
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic load_timings(input logic [CFG_W-1:0] vals [CFG_NUM]);
    wait_drained();
    for (int i = 0; i < CFG_NUM; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= CFG_IDX_W'(i);
      cfg_data <= vals[i];
      slot_cfg[i] = vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_idle_items();
    send_word(in_t'{ACT_TICK, 8'hFF, 1'b1});
    send_word(in_t'{ACT_TICK, 8'h00, 1'b0});
    send_word(in_t'{ACT_SPARE0, 8'hFF, 1'b1});
    send_word(in_t'{ACT_SPARE1, 8'h00, 1'b0});
  endtask

  task automatic test_default_timing();
    run_op(ACT_WBIT, 8'h01, 8'h00, 1, 0);
    run_op(ACT_RBIT, 8'h00, 8'h01, 0, 0);
  endtask

  task automatic test_short_slots();
    logic [CFG_W-1:0] vals [CFG_NUM];
    foreach (vals[i]) vals[i] = CFG_W'(1);
    vals[CFG_WR0_HIGH] = '0;  // zero acts as one tick
    vals[CFG_READ_LOW] = '0;
    load_timings(vals);
    run_op(ACT_RESET, 8'h00, 8'h00, 0, 0);
    run_op(ACT_WBYTE, 8'hFF, 8'h00, 1, 0);
    run_op(ACT_WBYTE, 8'h00, 8'h00, 1, 0);
    run_op(ACT_WBIT, 8'hFE, 8'h00, 1, 0);
    run_op(ACT_RBYTE, 8'h00, 8'hA5, 0, 0);
    // a write byte starts on the idle bus, commands sent while it is busy are refused, spare actions still do nothing
    send_word(in_t'{ACT_WBYTE, 8'hA5, 1'b0});
    send_word(in_t'{ACT_RESET, 8'h00, 1'b0});
    send_word(in_t'{ACT_RBYTE, 8'hFF, 1'b1});
    send_word(in_t'{ACT_SPARE1, 8'h5A, 1'b1});
    run_out(8'h00, 1, 0);
  endtask

  task automatic test_backpressure();
    int keep_pct;
    keep_pct = send_idle_pct;
    wait_drained();
    send_idle_pct = 0;
    hold_left = 400;  // output held off while ticks keep coming
    run_op(ACT_WBYTE, 8'h5A, 8'h00, 1, 0);
    run_op(ACT_RBIT, 8'h00, 8'h00, 1, 0);
    send_idle_pct = keep_pct;
  endtask

  task automatic test_long_slots();
    logic [CFG_W-1:0] vals [CFG_NUM];
    foreach (vals[i]) vals[i] = CFG_W'(64);
    load_timings(vals);
    run_op(ACT_WBIT, 8'h01, 8'h00, 1, 0);
  endtask

  task automatic test_random(input int snd_pct, input int rcv_pct, input int n_items);
    logic [CFG_W-1:0] vals [CFG_NUM];
    int               goal;
    int               pick;
    in_t              w;
    wait_drained();
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    foreach (vals[i])
      vals[i] = CFG_W'(($urandom_range(7) == 0) ? $urandom_range(13, 40)
                                                : $urandom_range(0, 6));
    load_timings(vals);
    goal = work_items + n_items;
    while (work_items < goal) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        // stray word on an idle bus
        w.action     = (pick < 3) ? ACT_TICK : ((pick < 5) ? ACT_SPARE0 : ACT_SPARE1);
        w.tx_data    = 8'($urandom);
        w.line_level = 1'($urandom);
        send_word(w);
      end else if (pick < 24) begin
        run_op(ACT_RESET, 8'($urandom), 8'h00, 1, 4);
      end else if (pick < 46) begin
        run_op(ACT_WBIT, 8'($urandom), 8'h00, 1, 4);
      end else if (pick < 70) begin
        run_op(ACT_WBYTE, 8'($urandom), 8'h00, 1, 4);
      end else begin
        run_op(ACT_RBIT, 8'($urandom), 8'h00, 1, 4);
      end
    end
  endtask

  // ---------------------------------------------------------------- receiver side
  initial begin
    forever begin
      @(posedge clk);
      out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_idle_pct);
      if (hold_left > 0) hold_left--;
    end
  end

  initial begin
    out_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          flag_error($sformatf("unexpected word %h", out_word));
        end else begin
          want = expected_words.pop_front();
          check_field("pull_low", 8'(out_word.pull_low), 8'(want.pull_low));
          check_field("busy", 8'(out_word.busy_res), 8'(want.busy_res));
          check_field("done", 8'(out_word.done_res), 8'(want.done_res));
          check_field("presence", 8'(out_word.presence), 8'(want.presence));
          check_field("rx_data", out_word.rx_data, want.rx_data);
          check_field("rejected", 8'(out_word.rejected), 8'(want.rejected));
        end
      end
    end
  end

  initial begin
    foreach (slot_cfg[i]) slot_cfg[i] = CFG_DEFAULT[i];
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_items();
    test_default_timing();
    test_short_slots();
    test_backpressure();
    test_long_slots();
    test_random(6, 58, 40);
    test_random(58, 6, 40);
    test_random(0, 0, 40);
    wait_drained();
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
